// ----- rtl/longest_increasing_subsequence_top_macros.svh -----
// Assertion macros for the LIS block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define LIS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define LIS_ASSERT(lbl, prop, msg)
`define LIS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- rtl/lis_pkg.sv -----
package lis_pkg;

  // Sequence limits
  localparam int unsigned MAX_ITEMS  = 1024;
  localparam int unsigned VALUE_BITS = 16;

  // Table index and count widths
  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  // Fixed port widths
  localparam int unsigned IN_VALUE_W = 16;
  localparam int unsigned LEVEL_W    = 11;
  localparam int unsigned INDEX_W    = 10;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Search sequencer states
  typedef enum logic {
    SR_IDLE,
    SR_SEARCH
  } srch_state_e;

  // Search start request
  typedef struct packed {
    logic start;
    val_t value;
    cnt_t hi;
  } srch_req_t;

  // Search completion
  typedef struct packed {
    logic done;
    cnt_t lo;
  } srch_rsp_t;

  // Tails memory port
  typedef struct packed {
    logic wr_en;
    idx_t wr_addr;
    val_t wr_data;
    idx_t rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/longest_increasing_subsequence_top.sv -----
// Streaming longest strictly increasing subsequence.
// Input channel (in_valid_i/in_ready_o) takes one value per item, with
// new_sequence_i set on the first item of a new sequence. Output channel
// (out_valid_o/out_ready_i) returns one result per item: the level the
// value reached, the best length so far, the index of the latest item at
// the best length, and an overflow flag for items past MAX_ITEMS.
// Each item runs a binary search over the tails memory through a single
// comparator, one tail read and one compare per cycle. The search writes
// the tail in its last compare, or in the accept cycle when the table is
// empty; the result is registered at the end of that cycle. Overflow items
// skip the search, and their result is registered in the accept cycle. One
// item is in work at a time; in_ready_o rises together with the result
// when the receiver is ready.
// A stalled receiver holds the result in the output register and keeps
// in_ready_o low until it is taken.
// Reset clears the lengths, the item count and the handshake state; the
// tails memory is not cleared and needs no sweep, since only entries
// written in the current sequence are ever read.
module longest_increasing_subsequence_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lis_pkg::IN_VALUE_W-1:0] value_i,
  input  logic                           new_sequence_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lis_pkg::LEVEL_W-1:0]    level_o,
  output logic [lis_pkg::LEVEL_W-1:0]    best_length_o,
  output logic [lis_pkg::INDEX_W-1:0]    best_end_index_o,
  output logic                           overflow_o
);
  import lis_pkg::*;

  `include "longest_increasing_subsequence_top_macros.svh"

  srch_req_t req;
  srch_rsp_t rsp;
  mem_req_t  mem_req;
  val_t      rdata;

  logic busy_q, busy_d;
  cnt_t run_length_q, run_length_d;
  cnt_t item_count_q, item_count_d;
  idx_t end_index_q, end_index_d;

  logic                out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]  out_level_q, out_level_d;
  logic [LEVEL_W-1:0]  out_best_q, out_best_d;
  logic [INDEX_W-1:0]  out_end_q, out_end_d;
  logic                out_ovf_q, out_ovf_d;

  logic accept;
  cnt_t run_eff, cnt_eff, level_c;
  idx_t end_eff;
  cnt_t run_cur, cnt_cur;
  idx_t end_cur;
  logic ovf_in, new_best;

  lis_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .mem_o   (mem_req),
    .rdata_i (rdata)
  );

  lis_tails_mem u_tails (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (rdata)
  );

  // Accept when idle and the output slot is free or being emptied
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // State seen by this item after an optional restart
  always_comb begin
    run_eff = new_sequence_i ? '0 : run_length_q;
    cnt_eff = new_sequence_i ? '0 : item_count_q;
    end_eff = new_sequence_i ? '0 : end_index_q;
    ovf_in  = cnt_eff >= CNT_W'(MAX_ITEMS);

    req.start = accept && !ovf_in;
    req.value = value_i[VALUE_BITS-1:0];
    req.hi    = run_eff;

    // An empty-table search ends in its accept cycle, before the restart is stored
    run_cur = accept ? run_eff : run_length_q;
    cnt_cur = accept ? cnt_eff : item_count_q;
    end_cur = accept ? end_eff : end_index_q;

    level_c  = rsp.lo + CNT_W'(1);
    new_best = level_c >= run_cur;
  end

  // Running state and result register
  always_comb begin
    busy_d       = busy_q;
    run_length_d = run_length_q;
    item_count_d = item_count_q;
    end_index_d  = end_index_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_level_d  = out_level_q;
    out_best_d   = out_best_q;
    out_end_d    = out_end_q;
    out_ovf_d    = out_ovf_q;

    if (accept) begin
      run_length_d = run_eff;
      item_count_d = cnt_eff;
      end_index_d  = end_eff;
      if (ovf_in) begin
        out_valid_d = 1'b1;
        out_level_d = '0;
        out_best_d  = LEVEL_W'(run_eff);
        out_end_d   = INDEX_W'(end_eff);
        out_ovf_d   = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end

    if (rsp.done) begin
      busy_d       = 1'b0;
      item_count_d = cnt_cur + CNT_W'(1);
      out_valid_d  = 1'b1;
      out_level_d  = LEVEL_W'(level_c);
      out_ovf_d    = 1'b0;
      if (new_best) begin
        run_length_d = level_c;
        end_index_d  = cnt_cur[IDX_W-1:0];
        out_best_d   = LEVEL_W'(level_c);
        out_end_d    = INDEX_W'(cnt_cur[IDX_W-1:0]);
      end else begin
        out_best_d   = LEVEL_W'(run_cur);
        out_end_d    = INDEX_W'(end_cur);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      run_length_q <= '0;
      item_count_q <= '0;
      end_index_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      run_length_q <= run_length_d;
      item_count_q <= item_count_d;
      end_index_q  <= end_index_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_level_q <= out_level_d;
    out_best_q  <= out_best_d;
    out_end_q   <= out_end_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign level_o          = out_level_q;
  assign best_length_o    = out_best_q;
  assign best_end_index_o = out_end_q;
  assign overflow_o       = out_ovf_q;

  // Checks
  `LIS_ASSERT(a_run_le_count, run_length_q <= item_count_q, "best length exceeds item count")
  `LIS_ASSERT(a_count_bound, item_count_q <= CNT_W'(MAX_ITEMS), "item count past limit")
  `LIS_ASSERT(a_done_when_busy, rsp.done |-> (busy_q || accept), "search done with no item")
  `LIS_ASSERT(a_done_slot_free, rsp.done |-> (!out_valid_q || out_ready_i),
              "search result would overwrite a pending result")

endmodule

// ----- rtl/lis_tails_mem.sv -----
module lis_tails_mem (
  input  logic              clk_i,
  input  lis_pkg::mem_req_t mem_i,
  output lis_pkg::val_t     rdata_o
);
  import lis_pkg::*;

  val_t mem_q [MAX_ITEMS];
  val_t rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_i.wr_en) begin
      mem_q[mem_i.wr_addr] <= mem_i.wr_data;
    end
    rdata_q <= mem_q[mem_i.rd_addr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lis_search.sv -----
module lis_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lis_pkg::srch_req_t req_i,
  output lis_pkg::srch_rsp_t rsp_o,
  output lis_pkg::mem_req_t  mem_o,
  input  lis_pkg::val_t      rdata_i
);
  import lis_pkg::*;

  srch_state_e state_q, state_d;

  cnt_t lo_q, lo_d;
  cnt_t hi_q, hi_d;
  cnt_t mid_q, mid_d;
  val_t val_q, val_d;

  logic less;
  cnt_t lo_n, hi_n, mid_n, half_hi;
  logic found;

  // Shared compare step: narrow [lo, hi) around the tail read at mid
  always_comb begin
    less    = rdata_i < val_q;
    lo_n    = less ? mid_q + CNT_W'(1) : lo_q;
    hi_n    = less ? hi_q : mid_q;
    mid_n   = lo_n + ((hi_n - lo_n) >> 1);
    found   = lo_n >= hi_n;
    half_hi = req_i.hi >> 1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SR_IDLE: begin
        if (req_i.start && (req_i.hi != '0)) begin
          state_d = SR_SEARCH;
        end
      end
      SR_SEARCH: begin
        if (found) begin
          state_d = SR_IDLE;
        end
      end
      default: state_d = SR_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    mem_o   = '0;
    rsp_o   = '0;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    val_d   = val_q;
    unique case (state_q)
      SR_IDLE: begin
        if (req_i.start) begin
          lo_d  = '0;
          hi_d  = req_i.hi;
          mid_d = half_hi;
          val_d = req_i.value;
          if (req_i.hi == '0) begin
            // Empty table: value goes straight to the first tail
            mem_o.wr_en   = 1'b1;
            mem_o.wr_addr = '0;
            mem_o.wr_data = req_i.value;
            rsp_o.done    = 1'b1;
            rsp_o.lo      = '0;
          end else begin
            mem_o.rd_addr = half_hi[IDX_W-1:0];
          end
        end
      end
      SR_SEARCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n;
        if (found) begin
          mem_o.wr_en   = 1'b1;
          mem_o.wr_addr = lo_n[IDX_W-1:0];
          mem_o.wr_data = val_q;
          rsp_o.done    = 1'b1;
          rsp_o.lo      = lo_n;
        end else begin
          mem_o.rd_addr = mid_n[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search bounds and value
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    val_q <= val_d;
  end

endmodule
